// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MODE      = 2'd0,
		REG_ROW_WIDTH = 2'd1,
		REG_MAX_VALUE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_COLOUR = 1'b0,
		MODE_BITMAP = 1'b1
	} mode_t;

	// colour channel order within a triplet
	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} channel_t;

	localparam int SUM_BITS = 18;	// 1000 * 255 fits in 18 bits

	localparam logic [SUM_BITS-1:0] GRAY_R = SUM_BITS'(299);
	localparam logic [SUM_BITS-1:0] GRAY_G = SUM_BITS'(587);
	localparam logic [SUM_BITS-1:0] GRAY_B = SUM_BITS'(114);

	// floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 2^18
	localparam int RECIP_BITS  = 19;
	localparam int RECIP_SHIFT = 28;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(268436);
	localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

	localparam int CFG_BITS = 16;	// widest register: row_width

endpackage

// ----- rtl/core/binary_pixel_converter.sv -----
// Raw image body converter. A stream of 8-bit words enters on the s_ side and
// converted words leave on the m_ side. In colour mode (mode = 0) words are taken
// as red, green and blue in turn and every third word yields one gray word
// (299R + 587G + 114B) / 1000, truncated. In bitmap mode (mode = 1) each word is
// a gray pixel that becomes bit 0 when above (max_value + 1) / 2, else bit 1;
// bits pack MSB first and a word leaves after eight pixels or at the end of a
// row of row_width pixels, a short word padded with ones. Each mode keeps its
// own partial state across mode changes. One word is accepted per clock while
// s_tready is high. A result passes the input register, the sum stage, then the
// reciprocal multiply for the divide by 1000 into the output register, which
// drives m_tdata; s_tready only drops when all three stages hold data and the
// output side is not taking a word. The configuration port must be written
// only while the block is idle; the block itself does not enforce this.
module binary_pixel_converter
	import bpc_pkg::*;
#(
	parameter int COLUMN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	// configuration write port
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,

	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,	// [7:0] sample

	// output stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata	// [7:0] out_byte
);

	localparam int RW_BITS = (COLUMN_BITS > CFG_BITS) ? COLUMN_BITS : CFG_BITS;

	// configuration registers
	mode_t                mode_q;
	logic [CFG_BITS-1:0]  row_width_q;
	logic [7:0]           max_value_q;

	// colour state
	channel_t             channel_q;
	logic [7:0]           red_q;
	logic [SUM_BITS-1:0]  partial_q;	// 299R + 587G, held until blue arrives

	// bitmap state
	logic [7:0]           shift_q;
	logic [3:0]           count_q;
	logic [COLUMN_BITS-1:0] column_q;

	// pipeline
	logic                 valid_s1;
	logic [7:0]           sample_s1;
	logic                 valid_s2;
	logic                 gray_s2;	// word still needs the divide
	logic [SUM_BITS-1:0]  sum_s2;
	logic [7:0]           byte_s2;
	logic                 valid_s3;
	logic [7:0]           byte_s3;

	logic en1, en2, en3;

	// per-stage advance: a stage moves when it is empty or the next one moves
	assign en3      = !valid_s3 || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = valid_s3;
	assign m_tdata  = byte_s3;

	// bitmap datapath
	logic [8:0]             threshold;
	logic                   pix_bit;
	logic [COLUMN_BITS-1:0] next_col;
	logic [RW_BITS-1:0]     rw_wide;
	logic                   row_end;
	logic [7:0]             new_shift;
	logic [3:0]             new_count;
	logic [3:0]             fill;
	logic                   bm_emit;
	logic [7:0]             bm_value;

	always_comb begin
		threshold = (9'(max_value_q) + 9'd1) >> 1;
		pix_bit   = (9'(sample_s1) > threshold) ? 1'b0 : 1'b1;
		next_col  = column_q + COLUMN_BITS'(1);
		rw_wide   = RW_BITS'(row_width_q);
		row_end   = (next_col == rw_wide[COLUMN_BITS-1:0]);
		new_shift = {shift_q[6:0], pix_bit};
		new_count = count_q + 4'd1;
		fill      = 4'd8 - new_count;
		bm_emit   = row_end || (new_count >= 4'd8);
		// pad a short word with ones below the collected bits
		bm_value  = (new_shift << fill) | ~(8'hFF << fill);
	end

	// colour datapath
	logic [SUM_BITS-1:0] green_sum;
	logic [SUM_BITS-1:0] full_sum;
	logic [PROD_BITS-1:0] product;

	assign green_sum = SUM_BITS'(red_q) * GRAY_R + SUM_BITS'(sample_s1) * GRAY_G;
	assign full_sum  = partial_q + SUM_BITS'(sample_s1) * GRAY_B;
	assign product   = PROD_BITS'(sum_s2) * PROD_BITS'(RECIP);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_COLOUR;
			row_width_q <= CFG_BITS'(1);
			max_value_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= mode_t'(cfg_data[0]);
				REG_ROW_WIDTH: row_width_q <= cfg_data;
				REG_MAX_VALUE: max_value_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			sample_s1 <= s_tdata;
		end
	end

	// conversion state and stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CH_RED;
			red_q     <= 8'd0;
			partial_q <= '0;
			shift_q   <= 8'd0;
			count_q   <= 4'd0;
			column_q  <= '0;
			valid_s2  <= 1'b0;
			gray_s2   <= 1'b0;
			sum_s2    <= '0;
			byte_s2   <= 8'd0;
		end else if (en2) begin
			valid_s2 <= 1'b0;
			if (valid_s1) begin
				if (mode_q == MODE_COLOUR) begin
					case (channel_q)
						CH_RED: begin
							red_q     <= sample_s1;
							channel_q <= CH_GREEN;
						end
						CH_GREEN: begin
							partial_q <= green_sum;
							channel_q <= CH_BLUE;
						end
						default: begin
							sum_s2    <= full_sum;
							gray_s2   <= 1'b1;
							valid_s2  <= 1'b1;
							channel_q <= CH_RED;
						end
					endcase
				end else begin
					column_q <= next_col;
					if (bm_emit) begin
						byte_s2  <= bm_value;
						gray_s2  <= 1'b0;
						valid_s2 <= 1'b1;
						shift_q  <= 8'd0;
						count_q  <= 4'd0;
						if (row_end) begin
							column_q <= '0;
						end
					end else begin
						shift_q <= new_shift;
						count_q <= new_count;
					end
				end
			end
		end
	end

	// stage 3: divide by 1000 through the reciprocal, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			byte_s3 <= gray_s2 ? product[RECIP_SHIFT+7:RECIP_SHIFT] : byte_s2;
		end
	end

	// checks
	a_channel_legal: assert property (@(posedge clk) disable iff (!arst_n)
		channel_q != 2'd3)
		else $error("colour channel index out of range");

	a_count_below_byte: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < 4'd8)
		else $error("full bitmap word left unflushed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en2 |=> valid_s1 && $stable(sample_s1))
		else $error("stalled input word lost");

endmodule

// ----- tb/binary_pixel_converter_test.sv -----
`timescale 1ns / 100ps

module binary_pixel_converter_test;
	import bpc_pkg::*;

	// clock, reset and block ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;	// [7:0] sample
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;	// [7:0] out_byte

	// words the converter still owes us, oldest first
	logic [7:0] pending_out_bytes[$];
	int         mismatch_count = 0;

	// no idling on either side while set
	bit steady = 1'b0;
	// cycles the output side must hold off, picked up by the ready process
	int hold_request = 0;

	// shadow copy of the configuration registers
	mode_t       cur_mode = MODE_COLOUR;
	logic [15:0] row_w = 16'd1;
	logic [7:0]  max_v = 8'd255;

	// shadow copy of the conversion state
	channel_t    chan = CH_RED;
	logic [7:0]  red_q = '0;
	logic [7:0]  green_q = '0;
	logic [7:0]  pack_bits = '0;
	logic [3:0]  pack_cnt = '0;
	logic [15:0] col_cnt = '0;

	binary_pixel_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the shadow state by one accepted sample, returns 1 when a word is due
	function automatic bit convert_sample(input logic [7:0] s, output logic [7:0] res);
		int   sum;
		int   thr;
		int   fill;
		logic pix;
		logic [15:0] next_col;
		logic row_end;
		res = '0;
		if (cur_mode == MODE_COLOUR) begin
			case (chan)
				CH_RED: begin
					red_q = s;
					chan = CH_GREEN;
					return 1'b0;
				end
				CH_GREEN: begin
					green_q = s;
					chan = CH_BLUE;
					return 1'b0;
				end
				default: begin
					// weighted luma, truncated
					sum = 299 * int'(red_q) + 587 * int'(green_q) + 114 * int'(s);
					res = 8'(sum / 1000);
					chan = CH_RED;
					return 1'b1;
				end
			endcase
		end
		// bitmap: dark pixel (at or below half scale) packs as a one
		thr = (int'(max_v) + 1) / 2;
		pix = (int'(s) > thr) ? 1'b0 : 1'b1;
		next_col = col_cnt + 16'd1;
		row_end = (next_col == row_w);
		pack_bits = {pack_bits[6:0], pix};
		pack_cnt = pack_cnt + 4'd1;
		col_cnt = next_col;
		if (!row_end && pack_cnt < 4'd8)
			return 1'b0;
		// short word at row end is filled with ones on the right
		fill = 8 - int'(pack_cnt);
		res = 8'((int'(pack_bits) << fill) | ((1 << fill) - 1));
		pack_bits = '0;
		pack_cnt = '0;
		if (row_end)
			col_cnt = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// offer one sample, with an occasional idle burst ahead of it
	task automatic push_sample(input logic [7:0] s);
		int         gap;
		logic [7:0] res;
		if (!steady && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= s;
		do @(posedge clk); while (!s_tready);
		if (convert_sample(s, res))
			pending_out_bytes.push_back(res);
	endtask

	// stop offering and let every owed word come out, plus the pipeline depth
	task automatic drain_pipeline();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_out_bytes.size() != 0)
			@(negedge clk);
		// a partial triplet or bit group may still sit in the stages
		repeat (6) @(negedge clk);
	endtask

	// registers are only touched while the block is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		drain_pipeline();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:      cur_mode = mode_t'(val[0]);
			REG_ROW_WIDTH: row_w = val;
			default:       max_v = val[7:0];
		endcase
	endtask

	// samples lean toward the threshold edge and the range ends
	function automatic logic [7:0] pick_sample();
		int thr;
		thr = (int'(max_v) + 1) / 2;
		case ($urandom_range(0, 7))
			0:       return 8'(thr);
			1:       return 8'(thr + 1);
			2:       return 8'h00;
			3:       return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_width();
		case ($urandom_range(0, 15))
			0, 1:    return 16'd1;
			2, 3:    return 16'd8;
			4:       return 16'd16;
			5:       return 16'($urandom_range(100, 300));
			default: return 16'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [7:0] pick_max();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd1;
			3:       return 8'd254;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// colour triplets: black, white, magenta, pure green
	task automatic test_colour_gray();
		push_sample(8'd0);   push_sample(8'd0);   push_sample(8'd0);
		push_sample(8'd255); push_sample(8'd255); push_sample(8'd255);
		push_sample(8'd255); push_sample(8'd0);   push_sample(8'd255);
		push_sample(8'd0);   push_sample(8'd255); push_sample(8'd0);
	endtask

	// bitmap packing: full row on a word boundary, short padded row, one-pixel rows
	task automatic test_bitmap_packing();
		write_reg(REG_MODE, 16'(MODE_BITMAP));
		write_reg(REG_ROW_WIDTH, 16'd8);
		write_reg(REG_MAX_VALUE, 16'd255);
		push_sample(8'd128); push_sample(8'd129); push_sample(8'd0);   push_sample(8'd255);
		push_sample(8'd127); push_sample(8'd200); push_sample(8'd1);   push_sample(8'd128);
		write_reg(REG_ROW_WIDTH, 16'd3);
		push_sample(8'd129); push_sample(8'd0);   push_sample(8'd255);
		// threshold of zero: only a zero pixel is dark
		write_reg(REG_MAX_VALUE, 16'd0);
		write_reg(REG_ROW_WIDTH, 16'd1);
		push_sample(8'd0);   push_sample(8'd1);
	endtask

	// each mode resumes its own partial work after the other one ran
	task automatic test_mode_switch();
		write_reg(REG_MAX_VALUE, 16'd255);
		write_reg(REG_ROW_WIDTH, 16'd3);
		write_reg(REG_MODE, 16'(MODE_COLOUR));
		push_sample(8'd200); push_sample(8'd17);
		write_reg(REG_MODE, 16'(MODE_BITMAP));
		push_sample(8'd10);  push_sample(8'd250);
		write_reg(REG_MODE, 16'(MODE_COLOUR));
		push_sample(8'd90);
		write_reg(REG_MODE, 16'(MODE_BITMAP));
		push_sample(8'd3);
	endtask

	// output side holds off long while we keep offering, so the input must stall
	task automatic test_backpressure();
		write_reg(REG_MODE, 16'(MODE_COLOUR));
		steady = 1'b1;
		hold_request = 80;
		repeat (60) push_sample(8'($urandom_range(0, 255)));
		drain_pipeline();
		steady = 1'b0;
	endtask

	// random runs between random register settings
	task automatic test_random_stream();
		int sent;
		int n;
		sent = 0;
		write_reg(REG_ROW_WIDTH, 16'd5);
		while (sent < 850) begin
			write_reg(REG_MODE, 16'($urandom_range(0, 1)));
			if ($urandom_range(0, 1))
				write_reg(REG_MAX_VALUE, 16'(pick_max()));
			// row width only changes on a row boundary
			if (col_cnt == 16'd0 && $urandom_range(0, 1))
				write_reg(REG_ROW_WIDTH, pick_width());
			n = $urandom_range(5, 60);
			repeat (n) push_sample(pick_sample());
			sent += n;
			// sometimes close the row so the width can move
			if (cur_mode == MODE_BITMAP && col_cnt != 16'd0 && $urandom_range(0, 2) == 0)
				repeat (int'(row_w) - int'(col_cnt)) push_sample(pick_sample());
		end
	endtask

	// very wide row and zero width pack plain groups of eight, then a narrow
	// width set just past the column count closes the row
	task automatic test_long_rows();
		steady = 1'b1;
		write_reg(REG_MODE, 16'(MODE_BITMAP));
		write_reg(REG_MAX_VALUE, 16'($urandom_range(0, 255)));
		write_reg(REG_ROW_WIDTH, 16'hffff);
		repeat (40) push_sample(8'($urandom_range(0, 255)));
		write_reg(REG_ROW_WIDTH, 16'd0);
		repeat (40) push_sample(8'($urandom_range(0, 255)));
		write_reg(REG_ROW_WIDTH, col_cnt + 16'd5);
		repeat (5) push_sample(8'($urandom_range(0, 255)));
	endtask

	// back to back words with no idling at all
	task automatic test_steady_tail();
		steady = 1'b1;
		write_reg(REG_ROW_WIDTH, 16'd13);
		write_reg(REG_MAX_VALUE, 16'd200);
		repeat (120) push_sample(pick_sample());
		write_reg(REG_MODE, 16'(MODE_COLOUR));
		repeat (60) push_sample(8'($urandom_range(0, 255)));
	endtask

	// output side: random stall bursts, or a long hold when asked
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		while (!arst_n) @(negedge clk);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare every taken word with the oldest owed one
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out_bytes.size() == 0) begin
				report_mismatch($sformatf("word %02h with nothing owed", m_tdata));
			end else begin
				want = pending_out_bytes.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want));
			end
		end
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("FAIL binary_pixel_converter");
		$finish;
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_colour_gray();
		test_bitmap_packing();
		test_mode_switch();
		test_backpressure();
		test_random_stream();
		test_long_rows();
		test_steady_tail();

		drain_pipeline();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_out_bytes.size() == 0) begin
			$display("PASS binary_pixel_converter");
		end else begin
			$display("FAIL binary_pixel_converter");
		end
		$finish;
	end

endmodule
